[design/jsji_pkg.sv]
`default_nettype none

package jsji_pkg;

    localparam int AXIS_W   = 10;
    localparam int TRIG_W   = 10;
    localparam int TICK_W   = 12;
    localparam int SPEED_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    localparam int PITCH_HOME_DEG = 105;
    localparam int JOINT_HOME_DEG = 90;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MAX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_MIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_MAX  = 3'd7;

    localparam logic [8:0]  RST_DEADZONE   = 9'd30;
    localparam logic [11:0] RST_BASE_SPEED = 12'd384;
    localparam logic [8:0]  RST_SLOW_SCALE = 9'd51;
    localparam logic [10:0] RST_FAST_SCALE = 11'd768;
    localparam logic [11:0] RST_PITCH_MIN  = 12'd67;
    localparam logic [11:0] RST_PITCH_MAX  = 12'd502;
    localparam logic [11:0] RST_JOINT_MIN  = 12'd125;
    localparam logic [11:0] RST_JOINT_MAX  = 12'd575;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [8:0]        deadzone;
        logic [11:0]       base;
        logic [TICK_W-1:0] lo;
        logic [TICK_W-1:0] hi;
    } t_lane_cfg;

endpackage

`default_nettype wire

[design/jsji_speed.sv]
`default_nettype none

module jsji_speed (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [jsji_pkg::TRIG_W-1:0]   i_brake,
    input  wire logic [jsji_pkg::TRIG_W-1:0]   i_throttle,
    input  wire logic [8:0]                    i_slow,
    input  wire logic [10:0]                   i_fast,
    output logic                               o_valid,
    output logic [jsji_pkg::SPEED_W-1:0]       o_speed
);
    import jsji_pkg::*;

    logic [2:0]         r_vld;
    logic signed [10:0] d;
    logic signed [11:0] k;
    logic signed [22:0] r_p;
    logic [20:0]        a;
    logic [21:0]        est;
    logic [20:0]        r_a;
    logic [11:0]        r_q0;
    logic               r_neg;
    logic [21:0]        rem;
    logic [11:0]        q;
    logic [SPEED_W-1:0] r_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    // trigger difference times the blend span
    always_comb begin
        d = $signed({1'b0, i_throttle}) - $signed({1'b0, i_brake});
        if (d > 0) begin
            k = $signed({1'b0, i_fast}) - 12'sd256;
        end else begin
            k = 12'sd256 - $signed({3'b0, i_slow});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= 23'(d) * 23'(k);
        end
    end

    // divide by 1023 through the series 1/1024 * (1 + 2^-10 + 2^-20)
    always_comb begin
        a   = r_p[22] ? 21'(-r_p) : r_p[20:0];
        est = 22'(a) + 22'(a >> 10) + 22'(a >> 20);
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[0]) begin
            r_a   <= a;
            r_q0  <= est[21:10];
            r_neg <= r_p[22];
        end
    end

    always_comb begin
        rem = 22'(r_a) - ({r_q0, 10'd0} - 22'(r_q0));
        q   = (rem >= 22'd1023) ? r_q0 + 12'd1 : r_q0;
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[1]) begin
            r_speed <= r_neg ? SPEED_W'(12'd256 - q) : SPEED_W'(12'd256 + q);
        end
    end

    assign o_valid = r_vld[2];
    assign o_speed = r_speed;

endmodule

`default_nettype wire

[design/jsji_lane.sv]
`default_nettype none

module jsji_lane #(
    parameter int RANGE_DEG = 180,
    parameter int HOME_DEG  = 90,
    parameter int FRAC_BITS = 8,
    parameter bit NEGATE    = 1'b0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [jsji_pkg::AXIS_W-1:0]   i_axis,
    input  wire logic [jsji_pkg::SPEED_W-1:0]  i_speed,
    input  wire logic                          i_home,
    input  wire jsji_pkg::t_lane_cfg           i_cfg,
    output logic                               o_done,
    output logic [jsji_pkg::TICK_W-1:0]        o_tick
);
    import jsji_pkg::*;

    localparam int NSTG = 10;
    localparam int AW   = 8 + FRAC_BITS;
    localparam int QW   = 8 + FRAC_BITS;
    localparam int YW   = 16 + FRAC_BITS;
    localparam int SH   = 16 - FRAC_BITS;
    localparam int AMW  = 20;
    localparam int DS   = 28;
    localparam int MW   = 29;
    localparam longint unsigned RECIP_L = (64'd1 << DS) / RANGE_DEG;
    localparam logic [MW-1:0] RECIP    = RECIP_L[MW-1:0];
    localparam logic [7:0]    RNG      = RANGE_DEG[7:0];
    localparam logic [AW-1:0] ANG_TOP  = AW'(RANGE_DEG) << FRAC_BITS;
    localparam logic [AW-1:0] ANG_HOME = AW'(HOME_DEG) << FRAC_BITS;

    logic [NSTG-1:0]      r_vld;
    logic [9:0]           mag;
    logic [9:0]           r_mag;
    logic                 r_neg;
    logic [21:0]          r_pa;
    logic [31:0]          r_pb;
    logic [YW-1:0]        y;
    logic [YW+1:0]        est;
    logic [YW-1:0]        r_y;
    logic [QW-1:0]        r_q0;
    logic [YW+1:0]        rem;
    logic [QW-1:0]        r_dq;
    logic signed [AW+1:0] v;
    logic [AW-1:0]        ang;
    logic [AW-1:0]        r_angle;
    logic [AW-1:0]        r_ang;
    logic [7:0]           deg;
    logic signed [12:0]   diff;
    logic signed [21:0]   r_prod;
    logic [AMW-1:0]       a;
    logic [AMW-1:0]       r_a;
    logic [AMW+MW-1:0]    r_am;
    logic                 r_tneg;
    logic [11:0]          tq0;
    logic [20:0]          tq0r;
    logic [20:0]          trem;
    logic [11:0]          r_tq;
    logic                 r_tneg2;
    logic [TICK_W-1:0]    r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], i_start};
        end
    end

    // deadzone and direction
    always_comb begin
        mag = i_axis[AXIS_W-1] ? 10'(-i_axis) : i_axis;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= (mag < {1'b0, i_cfg.deadzone}) ? 10'd0 : mag;
            r_neg <= i_axis[AXIS_W-1] ^ NEGATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[0]) begin
            r_pa <= 22'(r_mag) * 22'(i_cfg.base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[1]) begin
            r_pb <= 32'(33'(r_pa) * 33'(i_speed));
        end
    end

    // divide by 511 through the series 1/512 * (1 + 2^-9 + 2^-18 + ...)
    always_comb begin
        y   = YW'(r_pb >> SH);
        est = '0;
        for (int k = 0; 9 * k < YW; k++) begin
            est = est + (YW+2)'(y >> (9 * k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[2]) begin
            r_y  <= y;
            r_q0 <= est[9 +: QW];
        end
    end

    always_comb begin
        rem = (YW+2)'(r_y) - ((YW+2)'({r_q0, 9'd0}) - (YW+2)'(r_q0));
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[3]) begin
            r_dq <= (rem >= (YW+2)'(511)) ? r_q0 + QW'(1) : r_q0;
        end
    end

    // integrate and clamp to the joint range
    always_comb begin
        if (r_neg) begin
            v = $signed((AW+2)'(r_angle)) - $signed((AW+2)'(r_dq));
        end else begin
            v = $signed((AW+2)'(r_angle)) + $signed((AW+2)'(r_dq));
        end
        if (v[AW+1]) begin
            ang = '0;
        end else if (v > $signed((AW+2)'(ANG_TOP))) begin
            ang = ANG_TOP;
        end else begin
            ang = v[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= ANG_HOME;
        end else if (r_vld[4]) begin
            r_angle <= i_home ? ANG_HOME : ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[4]) begin
            r_ang <= ang;
        end
    end

    // tick mapping
    always_comb begin
        deg  = r_ang[AW-1:FRAC_BITS];
        diff = $signed({1'b0, i_cfg.hi}) - $signed({1'b0, i_cfg.lo});
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[5]) begin
            r_prod <= $signed(22'({1'b0, deg})) * 22'(diff);
        end
    end

    always_comb begin
        a = r_prod[21] ? AMW'(-r_prod) : r_prod[AMW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[6]) begin
            r_a    <= a;
            r_am   <= (AMW+MW)'(a) * (AMW+MW)'(RECIP);
            r_tneg <= r_prod[21];
        end
    end

    always_comb begin
        tq0  = r_am[DS +: 12];
        tq0r = 21'(tq0) * 21'(RNG);
        trem = 21'(r_a) - tq0r;
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[7]) begin
            r_tq    <= (trem >= 21'(RNG)) ? tq0 + 12'd1 : tq0;
            r_tneg2 <= r_tneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[8]) begin
            r_tick <= r_tneg2 ? i_cfg.lo - r_tq : i_cfg.lo + r_tq;
        end
    end

    assign o_done = r_vld[9];
    assign o_tick = r_tick;

endmodule

`default_nettype wire

[design/jsji_merge.sv]
`default_nettype none

module jsji_merge (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic [jsji_pkg::TICK_W-1:0]  i_pitch,
    input  wire logic [jsji_pkg::TICK_W-1:0]  i_yaw,
    input  wire logic [jsji_pkg::TICK_W-1:0]  i_elbow,
    input  wire logic [jsji_pkg::TICK_W-1:0]  i_wrist,
    input  wire logic                         i_ready,
    output logic                              o_valid,
    output logic [jsji_pkg::OUT_DATA_W-1:0]   o_data,
    output logic                              o_free
);
    import jsji_pkg::*;

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {i_wrist, i_elbow, i_yaw, i_pitch};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[design/joystick_servo_joint_integrator_unit.sv]
// channel    dir  fields (lowest bit first)
// s_axis     in   left_x, left_y, right_x, right_y, brake_trigger, throttle_trigger,
//                 home_request
// m_axis     out  pitch_tick, yaw_tick, elbow_tick, wrist_tick
// i_cfg_*    in   register write, index 0..7
//
// one sample at a time: from transfer in to result shown, a sample passes the
// input register (1), the speed divider (3 stages) and the 10-stage joint lanes
// the input reopens as the result is loaded, so no new sample enters before then
// a stalled output holds the finished ticks in the lanes until the register frees
// synchronous reset restores the config registers, the control state and the home pose

`default_nettype none

module joystick_servo_joint_integrator_unit #(
    parameter int PITCH_RANGE_DEG = 210,
    parameter int JOINT_RANGE_DEG = 180,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // left_x, left_y, right_x, right_y, brake_trigger, throttle_trigger, home_request
    input  wire logic [jsji_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // pitch_tick, yaw_tick, elbow_tick, wrist_tick
    output logic [jsji_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [jsji_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [jsji_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import jsji_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [8:0]         r_deadzone;
    logic [11:0]        r_base;
    logic [8:0]         r_slow;
    logic [10:0]        r_fast;
    logic [TICK_W-1:0]  r_pitch_min;
    logic [TICK_W-1:0]  r_pitch_max;
    logic [TICK_W-1:0]  r_joint_min;
    logic [TICK_W-1:0]  r_joint_max;

    logic [AXIS_W-1:0]  r_lx;
    logic [AXIS_W-1:0]  r_ly;
    logic [AXIS_W-1:0]  r_rx;
    logic [AXIS_W-1:0]  r_ry;
    logic [TRIG_W-1:0]  r_brake;
    logic [TRIG_W-1:0]  r_throttle;
    logic               r_home;
    logic               r_start;

    logic               accept;
    logic               spd_valid;
    logic [SPEED_W-1:0] speed;
    t_lane_cfg          pitch_cfg;
    t_lane_cfg          joint_cfg;
    logic [3:0]         done;
    logic [TICK_W-1:0]  pitch_tick;
    logic [TICK_W-1:0]  yaw_tick;
    logic [TICK_W-1:0]  elbow_tick;
    logic [TICK_W-1:0]  wrist_tick;
    logic               out_free;
    logic               load;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= RST_DEADZONE;
            r_base      <= RST_BASE_SPEED;
            r_slow      <= RST_SLOW_SCALE;
            r_fast      <= RST_FAST_SCALE;
            r_pitch_min <= RST_PITCH_MIN;
            r_pitch_max <= RST_PITCH_MAX;
            r_joint_min <= RST_JOINT_MIN;
            r_joint_max <= RST_JOINT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEADZONE:   r_deadzone  <= i_cfg_data[8:0];
                CFG_BASE_SPEED: r_base      <= i_cfg_data;
                CFG_SLOW_SCALE: r_slow      <= i_cfg_data[8:0];
                CFG_FAST_SCALE: r_fast      <= i_cfg_data[10:0];
                CFG_PITCH_MIN:  r_pitch_min <= i_cfg_data;
                CFG_PITCH_MAX:  r_pitch_max <= i_cfg_data;
                CFG_JOINT_MIN:  r_joint_min <= i_cfg_data;
                CFG_JOINT_MAX:  r_joint_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lx       <= s_axis_tdata[9:0];
            r_ly       <= s_axis_tdata[19:10];
            r_rx       <= s_axis_tdata[29:20];
            r_ry       <= s_axis_tdata[39:30];
            r_brake    <= s_axis_tdata[49:40];
            r_throttle <= s_axis_tdata[59:50];
            r_home     <= s_axis_tdata[60];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= accept;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (done[0]) begin
                    n_state = out_free ? ST_IDLE : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        load          = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_RUN:   load = (&done) && out_free;
            ST_DRAIN: load = out_free;
            default: ;
        endcase
    end

    jsji_speed u_speed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_brake    (r_brake),
        .i_throttle (r_throttle),
        .i_slow     (r_slow),
        .i_fast     (r_fast),
        .o_valid    (spd_valid),
        .o_speed    (speed)
    );

    assign pitch_cfg = '{deadzone: r_deadzone, base: r_base,
                         lo: r_pitch_min, hi: r_pitch_max};
    assign joint_cfg = '{deadzone: r_deadzone, base: r_base,
                         lo: r_joint_min, hi: r_joint_max};

    jsji_lane #(
        .RANGE_DEG (PITCH_RANGE_DEG),
        .HOME_DEG  (PITCH_HOME_DEG),
        .FRAC_BITS (ANGLE_FRAC_BITS),
        .NEGATE    (1'b1)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (spd_valid),
        .i_axis  (r_ly),
        .i_speed (speed),
        .i_home  (r_home),
        .i_cfg   (pitch_cfg),
        .o_done  (done[0]),
        .o_tick  (pitch_tick)
    );

    jsji_lane #(
        .RANGE_DEG (JOINT_RANGE_DEG),
        .HOME_DEG  (JOINT_HOME_DEG),
        .FRAC_BITS (ANGLE_FRAC_BITS),
        .NEGATE    (1'b0)
    ) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (spd_valid),
        .i_axis  (r_lx),
        .i_speed (speed),
        .i_home  (r_home),
        .i_cfg   (joint_cfg),
        .o_done  (done[1]),
        .o_tick  (yaw_tick)
    );

    jsji_lane #(
        .RANGE_DEG (JOINT_RANGE_DEG),
        .HOME_DEG  (JOINT_HOME_DEG),
        .FRAC_BITS (ANGLE_FRAC_BITS),
        .NEGATE    (1'b1)
    ) u_elbow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (spd_valid),
        .i_axis  (r_ry),
        .i_speed (speed),
        .i_home  (r_home),
        .i_cfg   (joint_cfg),
        .o_done  (done[2]),
        .o_tick  (elbow_tick)
    );

    jsji_lane #(
        .RANGE_DEG (JOINT_RANGE_DEG),
        .HOME_DEG  (JOINT_HOME_DEG),
        .FRAC_BITS (ANGLE_FRAC_BITS),
        .NEGATE    (1'b0)
    ) u_wrist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (spd_valid),
        .i_axis  (r_rx),
        .i_speed (speed),
        .i_home  (r_home),
        .i_cfg   (joint_cfg),
        .o_done  (done[3]),
        .o_tick  (wrist_tick)
    );

    jsji_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_pitch (pitch_tick),
        .i_yaw   (yaw_tick),
        .i_elbow (elbow_tick),
        .i_wrist (wrist_tick),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_free  (out_free)
    );

endmodule

`default_nettype wire

[design/jsji_checker.sv]
`default_nettype none

module jsji_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [jsji_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [jsji_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    // a transfer keeps the input closed while the sample works through
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready
            ##1 !s_axis_tready)
        else $error("input reopened too early after a transfer");

    // a new result rises only after the input has been closed
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without work in flight");

    // no result is shown straight after an input transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result shown directly after an input transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind joystick_servo_joint_integrator_unit jsji_checker u_jsji_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[dv/tb_joystick_servo_joint_integrator_unit.sv]
`default_nettype none

module tb_joystick_servo_joint_integrator_unit;
    import jsji_pkg::*;

    localparam int PITCH_RANGE    = 210;
    localparam int JOINT_RANGE    = 180;
    localparam int FRAC_BITS      = 8;
    localparam int TAIL_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_PHASES       = 8;
    localparam int ITEMS_PER_PHASE = 115;

    class joint_tick_predictor;
        longint deadzone, base_speed, slow_scale, fast_scale;
        longint pitch_lo, pitch_hi, joint_lo, joint_hi;
        longint pitch_ang, yaw_ang, elbow_ang, wrist_ang;
        logic [OUT_DATA_W-1:0] expected_ticks[$];
        int errors;
        int samples;
        int checked;

        function new();
            deadzone   = RST_DEADZONE;
            base_speed = RST_BASE_SPEED;
            slow_scale = RST_SLOW_SCALE;
            fast_scale = RST_FAST_SCALE;
            pitch_lo   = RST_PITCH_MIN;
            pitch_hi   = RST_PITCH_MAX;
            joint_lo   = RST_JOINT_MIN;
            joint_hi   = RST_JOINT_MAX;
            errors     = 0;
            samples    = 0;
            checked    = 0;
            go_home();
        endfunction

        function void go_home();
            pitch_ang = longint'(PITCH_HOME_DEG) << FRAC_BITS;
            yaw_ang   = longint'(JOINT_HOME_DEG) << FRAC_BITS;
            elbow_ang = longint'(JOINT_HOME_DEG) << FRAC_BITS;
            wrist_ang = longint'(JOINT_HOME_DEG) << FRAC_BITS;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEADZONE:   deadzone   = val[8:0];
                CFG_BASE_SPEED: base_speed = val[11:0];
                CFG_SLOW_SCALE: slow_scale = val[8:0];
                CFG_FAST_SCALE: fast_scale = val[10:0];
                CFG_PITCH_MIN:  pitch_lo   = val;
                CFG_PITCH_MAX:  pitch_hi   = val;
                CFG_JOINT_MIN:  joint_lo   = val;
                CFG_JOINT_MAX:  joint_hi   = val;
                default: ;
            endcase
        endfunction

        function longint dead_axis(logic [AXIS_W-1:0] raw);
            longint v;
            longint m;
            v = longint'($signed(raw));
            m = (v < 0) ? -v : v;
            return (m < deadzone) ? 0 : v;
        endfunction

        function longint step_delta(longint axis, longint speed);
            longint m;
            longint q;
            m = (axis < 0) ? -axis : axis;
            q = (m * base_speed * speed * (longint'(1) << FRAC_BITS)) / (longint'(511) << 16);
            return (axis < 0) ? -q : q;
        endfunction

        function longint move_angle(longint cur, longint delta, longint range);
            longint v;
            v = cur + delta;
            if (v < 0) v = 0;
            if (v > (range << FRAC_BITS)) v = range << FRAC_BITS;
            return v;
        endfunction

        function logic [TICK_W-1:0] angle_tick(longint ang, longint range, longint lo,
                                               longint hi);
            longint deg;
            longint t;
            deg = ang >> FRAC_BITS;
            if (deg > range) deg = range;
            t = lo + (deg * (hi - lo)) / range;
            return t[TICK_W-1:0];
        endfunction

        function void note_sample(logic [IN_DATA_W-1:0] d);
            longint lx, ly, rx, ry, diff, speed;
            logic [TICK_W-1:0] p, y, e, w;
            lx = dead_axis(d[9:0]);
            ly = dead_axis(d[19:10]);
            rx = dead_axis(d[29:20]);
            ry = dead_axis(d[39:30]);
            diff = longint'(d[59:50]) - longint'(d[49:40]);
            if (diff > 0)
                speed = 256 + (diff * (fast_scale - 256)) / 1023;
            else
                speed = 256 + (diff * (256 - slow_scale)) / 1023;
            pitch_ang = move_angle(pitch_ang, step_delta(-ly, speed), PITCH_RANGE);
            yaw_ang   = move_angle(yaw_ang, step_delta(lx, speed), JOINT_RANGE);
            elbow_ang = move_angle(elbow_ang, step_delta(-ry, speed), JOINT_RANGE);
            wrist_ang = move_angle(wrist_ang, step_delta(rx, speed), JOINT_RANGE);
            p = angle_tick(pitch_ang, PITCH_RANGE, pitch_lo, pitch_hi);
            y = angle_tick(yaw_ang, JOINT_RANGE, joint_lo, joint_hi);
            e = angle_tick(elbow_ang, JOINT_RANGE, joint_lo, joint_hi);
            w = angle_tick(wrist_ang, JOINT_RANGE, joint_lo, joint_hi);
            expected_ticks.push_back({w, e, y, p});
            // home pose applies after this step's ticks
            if (d[60]) go_home();
            samples++;
        endfunction

        function void check_ticks(logic [OUT_DATA_W-1:0] got);
            string names[4];
            logic [OUT_DATA_W-1:0] want;
            names = '{"pitch_tick", "yaw_tick", "elbow_tick", "wrist_tick"};
            if (expected_ticks.size() == 0) begin
                $error("unexpected result transfer, tdata %h", got);
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            checked++;
            for (int k = 0; k < 4; k++) begin
                if (got[k*TICK_W +: TICK_W] !== want[k*TICK_W +: TICK_W]) begin
                    $error("%s mismatch: expected %0d, actual %0d", names[k],
                           want[k*TICK_W +: TICK_W], got[k*TICK_W +: TICK_W]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    joint_tick_predictor sb;
    bit quiet = 1'b0;
    int idle_cycles = 0;
    int settings_used = 1;

    joystick_servo_joint_integrator_unit #(
        .PITCH_RANGE_DEG(PITCH_RANGE),
        .JOINT_RANGE_DEG(JOINT_RANGE),
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_ticks(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_sample(int lx, int ly, int rx, int ry,
                                                         int brk, int thr, bit home);
        return {3'b000, home, TRIG_W'(thr), TRIG_W'(brk), AXIS_W'(ry), AXIS_W'(rx),
                AXIS_W'(ly), AXIS_W'(lx)};
    endfunction

    function automatic int rand_axis();
        int v;
        case ($urandom_range(9))
            0: v = $urandom_range(1) ? 511 : -512;
            1: begin
                // either side of the deadzone edge
                v = int'(sb.deadzone) - 1 + $urandom_range(2);
                if (v > 511) v = 511;
                if (v < 0) v = 0;
                if ($urandom_range(1)) v = -v;
            end
            2: v = 0;
            3: v = $urandom_range(511, 300);
            4: v = -$urandom_range(512, 300);
            default: v = int'($signed(AXIS_W'($urandom_range(1023))));
        endcase
        return v;
    endfunction

    function automatic int rand_trigger();
        case ($urandom_range(7))
            0: return 0;
            1: return 1023;
            default: return $urandom_range(1023);
        endcase
    endfunction

    task automatic send_sample(input logic [IN_DATA_W-1:0] d);
        while (!quiet && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(int dz, int base, int slow, int fast,
                                  int plo, int phi, int jlo, int jhi);
        write_reg(CFG_DEADZONE, CFG_DATA_W'(dz));
        write_reg(CFG_BASE_SPEED, CFG_DATA_W'(base));
        write_reg(CFG_SLOW_SCALE, CFG_DATA_W'(slow));
        write_reg(CFG_FAST_SCALE, CFG_DATA_W'(fast));
        write_reg(CFG_PITCH_MIN, CFG_DATA_W'(plo));
        write_reg(CFG_PITCH_MAX, CFG_DATA_W'(phi));
        write_reg(CFG_JOINT_MIN, CFG_DATA_W'(jlo));
        write_reg(CFG_JOINT_MAX, CFG_DATA_W'(jhi));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed samples at reset settings
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0));
        send_sample(pack_sample(511, -512, -512, 511, 0, 1023, 0));
        send_sample(pack_sample(-512, 511, 511, -512, 1023, 0, 0));
        send_sample(pack_sample(29, -29, 30, -30, 500, 500, 0));
        send_sample(pack_sample(-30, 30, -29, 29, 0, 1, 0));
        send_sample(pack_sample(511, 511, 511, 511, 1023, 1023, 0));
        send_sample(pack_sample(300, -200, 100, -400, 0, 700, 1));
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0));
        repeat (10) send_sample(pack_sample(511, -512, 511, -512, 0, 1023, 0));
        repeat (3) send_sample(pack_sample(-512, 511, -512, 511, 1023, 0, 0));
        send_sample(pack_sample(-512, 511, -512, 511, 1023, 0, 1));
        send_sample(pack_sample(0, 0, 0, 0, 1, 0, 0));
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: ;
                1: apply_settings(0, 4095, 0, 2047, 0, 4095, 0, 4095);
                2: apply_settings(511, 2560, 511, 0, 4095, 0, 4095, 0);
                3: apply_settings(0, 0, 256, 256, 1000, 3000, 3000, 1000);
                4: apply_settings(30, 384, 51, 768, 67, 502, 125, 575);
                default: apply_settings($urandom_range(1) ? $urandom_range(63)
                                                          : $urandom_range(511),
                                        $urandom_range(4095), $urandom_range(511),
                                        $urandom_range(2047), $urandom_range(4095),
                                        $urandom_range(4095), $urandom_range(4095),
                                        $urandom_range(4095));
            endcase
            // one stretch with no idling on either side
            quiet = (ph == 5);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_sample(pack_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                                        rand_trigger(), rand_trigger(),
                                        $urandom_range(99) < 4));
            end
            drain();
            quiet = 1'b0;
        end

        $display("covered %0d samples across %0d register settings, %0d results checked",
                 sb.samples, settings_used, sb.checked);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
